@@ hdl/arp_cache_resolver_macros.svh @@
// Assertion macros for the ARP cache resolver.
// No dependencies.
`ifndef ARP_CACHE_RESOLVER_MACROS_SVH
`define ARP_CACHE_RESOLVER_MACROS_SVH
// implication check, clocked, disabled in reset
`define ACR_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication check
`define ACR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ hdl/acr_pkg.sv @@
// Shared types and constants for the ARP cache resolver.
// No dependencies.
package acr_pkg;
    localparam int ENTRIES = 8;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IN_W = 192;
    localparam int OUT_W = 136;

    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_HW = 3'd2;
    localparam logic [2:0] ST_BAD_PROTO = 3'd3;
    localparam logic [2:0] ST_BAD_SIZES = 3'd4;
    localparam logic [2:0] ST_BAD_OP = 3'd5;
    localparam logic [2:0] ST_NOT_OURS = 3'd6;

    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_REQ = 2'd1;
    localparam logic [1:0] SEND_REPLY = 2'd2;

    localparam logic [1:0] CFG_OWN_IP = 2'd0;
    localparam logic [1:0] CFG_NET_MASK = 2'd1;
    localparam logic [1:0] CFG_FIRST_WAIT = 2'd2;
    localparam logic [1:0] CFG_LONG_WAIT = 2'd3;

    localparam logic [47:0] MAC_ONES = '1;

    // one table entry as it moves down the chain
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] deadline;
        logic [30:0] wait_t;
    } t_entry;

    // scan token traveling alongside the entries
    typedef struct packed {
        logic [31:0] ip;
        logic [31:0] now;
        logic [30:0] long_wait;
        logic        found;
        logic [IDX_W-1:0] hit_idx;
        logic        free_found;
        logic [IDX_W-1:0] free_idx;
        logic        old_found;
        logic [IDX_W-1:0] old_idx;
        logic signed [32:0] oldest;
    } t_scan;

    function automatic logic mac_valid(input logic [47:0] m);
        return (m != 48'd0) && (m != MAC_ONES);
    endfunction
endpackage

@@ hdl/acr_cell.sv @@
// One entry cell of the ARP cache rotating ring; holds one entry.
// Depends on acr_pkg.
module acr_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  acr_pkg::t_entry i_load_val,
    input  logic            i_shift,
    input  acr_pkg::t_entry i_prev,
    output acr_pkg::t_entry o_entry
);
    import acr_pkg::*;
    t_entry r_entry;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_load) begin
            r_entry <= i_load_val;
        end else if (i_shift) begin
            r_entry <= i_prev;
        end
    end
    assign o_entry = r_entry;
endmodule

@@ hdl/acr_scan.sv @@
// Scan stage: compares the entry at the ring head with the scan token.
// Depends on acr_pkg.
module acr_scan (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  acr_pkg::t_scan           i_init,
    input  logic                     i_step,
    input  logic [acr_pkg::IDX_W-1:0] i_idx,
    input  acr_pkg::t_entry          i_head,
    output acr_pkg::t_scan           o_scan
);
    import acr_pkg::*;
    t_scan r_scan, n_scan;
    logic signed [32:0] w_left;
    always_comb begin
        n_scan = r_scan;
        w_left = 33'(signed'(i_head.deadline - r_scan.now));
        if (!r_scan.found && i_head.ip == r_scan.ip) begin
            n_scan.found = 1'b1;
            n_scan.hit_idx = i_idx;
        end
        if (!r_scan.free_found && i_head.ip == 32'd0) begin
            n_scan.free_found = 1'b1;
            n_scan.free_idx = i_idx;
        end
        if (w_left < r_scan.oldest) begin
            n_scan.oldest = w_left;
            n_scan.old_found = 1'b1;
            n_scan.old_idx = i_idx;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_start) begin
            r_scan <= i_init;
        end else if (i_step) begin
            r_scan <= n_scan;
        end
    end
    assign o_scan = r_scan;
endmodule

@@ hdl/arp_cache_resolver.sv @@
// Top level of the ARP cache resolver: ring of entry cells, scan, update.
// Depends on acr_pkg, acr_cell, acr_scan and arp_cache_resolver_macros.svh.
// The table is a ring of cells that rotates one entry per cycle past a
// single compare stage; the update state then writes the chosen entry and
// the output state presents the word. A tick skips the scan. The next word
// is accepted only after the previous result has been taken from the
// output register.
module arp_cache_resolver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // data_len, hw_type, proto_type, addr_sizes, opcode, peer_mac,
    // peer_ip, target_ip
    input  logic [acr_pkg::IN_W-1:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, mac_found, resolved_mac, send_kind, send_ip, send_mac
    output logic [acr_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import acr_pkg::*;
`include "arp_cache_resolver_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_UPD = 4'b0100, S_OUT = 4'b1000
    } t_state;

    t_state r_state;
    logic [31:0] r_own_ip, r_mask, r_now;
    logic [29:0] r_first;
    logic [30:0] r_long;
    logic [1:0]  r_req;
    logic [10:0] r_len;
    logic [15:0] r_hw, r_proto, r_sizes, r_op;
    logic [47:0] r_pmac;
    logic [31:0] r_pip, r_tip;
    logic [CNT_W-1:0] r_cnt;
    logic        r_ovalid;
    logic [OUT_W-1:0] r_odata;

    t_entry w_ent [ENTRIES];
    logic [ENTRIES-1:0] w_load;
    t_entry w_load_val;
    logic   w_shift;
    t_scan  w_scan, w_init;
    logic [IDX_W-1:0] w_idx;

    assign w_shift = (r_state == S_SCAN);
    assign w_idx = r_cnt[IDX_W-1:0];

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            acr_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_load[g]),
                .i_load_val(w_load_val), .i_shift(w_shift),
                .i_prev(w_ent[(g + 1) % ENTRIES]), .o_entry(w_ent[g])
            );
        end
    endgenerate

    // token is taken at the accepting edge, straight from the input word
    always_comb begin
        w_init = '0;
        w_init.ip = s_axis_tdata[154:123];
        w_init.now = r_now;
        w_init.long_wait = r_long;
        w_init.oldest = 33'(r_long);
    end

    acr_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_IDLE),
        .i_init(w_init), .i_step(w_shift), .i_idx(w_idx), .i_head(w_ent[0]),
        .o_scan(w_scan)
    );

    // frame check
    logic [2:0] w_status;
    always_comb begin
        if (r_len < 11'd28) w_status = ST_SHORT;
        else if (r_hw != 16'h0001) w_status = ST_BAD_HW;
        else if (r_proto != 16'h0800) w_status = ST_BAD_PROTO;
        else if (r_sizes != 16'h0604) w_status = ST_BAD_SIZES;
        else if (r_op != 16'd1 && r_op != 16'd2) w_status = ST_BAD_OP;
        else if (r_tip != r_own_ip) w_status = ST_NOT_OURS;
        else w_status = ST_OK;
    end

    // update decision
    logic             w_has, w_refresh, w_send, w_bcast;
    logic [IDX_W-1:0] w_e;
    t_entry           w_cur, w_new;
    logic [47:0]      w_newmac;
    logic signed [32:0] w_left;
    logic [31:0]      w_dl;
    logic [31:0]      w_dbl;
    logic             w_found;
    logic [47:0]      w_rmac;
    logic [1:0]       w_kind;
    logic [31:0]      w_sip;
    logic [47:0]      w_smac;
    logic [OUT_W-1:0] w_out;

    always_comb begin
        w_bcast = (r_pip | r_mask) == 32'hFFFF_FFFF;
        w_has = 1'b0; w_refresh = 1'b0; w_send = 1'b0;
        w_e = w_scan.hit_idx;
        if (w_scan.found) begin
            w_has = 1'b1;
        end else if (w_scan.free_found) begin
            w_has = 1'b1; w_e = w_scan.free_idx; w_refresh = 1'b1;
        end else if (w_scan.old_found) begin
            w_has = 1'b1; w_e = w_scan.old_idx; w_refresh = 1'b1;
        end
        w_cur = w_ent[w_e];
        w_newmac = (r_req == REQ_FRAME) ? r_pmac : 48'd0;
        w_new = w_cur;
        if (r_req == REQ_FRAME && w_has) w_refresh = 1'b1;
        if (w_refresh) begin
            if (r_pip != w_cur.ip) w_new.deadline = r_now;
            w_new.ip = r_pip;
            w_new.mac = w_newmac;
            w_new.wait_t = 31'(r_first);
        end
        w_left = 33'(signed'(w_new.deadline - r_now));
        w_dbl = {w_new.wait_t, 1'b0};
        w_dl = r_now + 32'(w_new.wait_t);
        if (w_has && w_new.ip != 32'd0 && !mac_valid(w_new.mac)
            && w_left <= 33'sd1) begin
            w_send = 1'b1;
            w_new.deadline = w_dl;
            if (w_new.wait_t < r_long)
                w_new.wait_t = w_dbl[31] ? 31'h7FFF_FFFF : w_dbl[30:0];
        end
        w_found = 1'b0; w_rmac = '0; w_kind = SEND_NONE; w_sip = '0; w_smac = '0;
        if (r_req == REQ_LOOKUP) begin
            if (w_bcast) begin
                w_found = 1'b1; w_rmac = MAC_ONES;
            end else begin
                if (w_has && mac_valid(w_new.mac)) begin
                    w_found = 1'b1; w_rmac = w_new.mac;
                end
                if (w_send) begin
                    w_kind = SEND_REQ; w_sip = w_new.ip;
                end
            end
        end else if (r_req == REQ_FRAME && w_status == ST_OK && r_op == 16'd1) begin
            w_kind = SEND_REPLY; w_sip = r_pip;
            w_smac = mac_valid(r_pmac) ? r_pmac : 48'd0;
        end
        w_out = '0;
        if (r_req == REQ_FRAME) w_out[2:0] = w_status;
        w_out[3] = w_found;
        w_out[51:4] = w_rmac;
        w_out[53:52] = w_kind;
        w_out[85:54] = w_sip;
        w_out[133:86] = w_smac;
    end

    logic w_write;
    assign w_write = (r_state == S_UPD) && w_has &&
        ((r_req == REQ_FRAME && w_status == ST_OK) ||
         (r_req == REQ_LOOKUP && !w_bcast));
    assign w_load_val = w_new;
    always_comb begin
        for (int i = 0; i < ENTRIES; i++)
            w_load[i] = w_write && (w_e == IDX_W'(i));
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0; r_mask <= 32'hFFFF_FF00;
            r_first <= 30'd1000; r_long <= 31'd1200000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_IP: r_own_ip <= i_cfg_data;
                CFG_NET_MASK: r_mask <= i_cfg_data;
                CFG_FIRST_WAIT: r_first <= i_cfg_data[29:0];
                CFG_LONG_WAIT: r_long <= i_cfg_data[30:0];
                default: r_long <= r_long;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req <= s_axis_tuser;
            r_len <= s_axis_tdata[10:0];
            r_hw <= s_axis_tdata[26:11];
            r_proto <= s_axis_tdata[42:27];
            r_sizes <= s_axis_tdata[58:43];
            r_op <= s_axis_tdata[74:59];
            r_pmac <= s_axis_tdata[122:75];
            r_pip <= s_axis_tdata[154:123];
            r_tip <= s_axis_tdata[186:155];
        end
        if (r_state == S_UPD) r_odata <= w_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_ovalid <= 1'b0; r_now <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_cnt <= '0;
                    r_state <= (s_axis_tuser == REQ_FRAME
                        || s_axis_tuser == REQ_LOOKUP) ? S_SCAN : S_UPD;
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ENTRIES - 1)) r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_req == REQ_TICK) r_now <= r_now + 32'd1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ACR_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `ACR_ASSERT_NXT(a_out_after_upd, i_clk, i_rst_n, r_state == S_OUT, m_axis_tvalid)
    `ACR_ASSERT_IMP(a_one_load, i_clk, i_rst_n, 1'b1, $countones(w_load) <= 1)
endmodule
